// File: rtl/core/sorted_term_list_defines.svh
// Assertion helpers for the sorted term list. They sample on i_clk and are
// disabled while i_rst_n is low.
`ifndef SORTED_TERM_LIST_DEFINES_SVH
`define SORTED_TERM_LIST_DEFINES_SVH

// same-cycle implication
`define STL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/stl_pkg.sv
package stl_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [15:0] coefficient;
        logic signed [15:0] exponent;
        logic        [7:0]  variable;
        logic        [7:0]  position;
    } t_in_word;

    typedef struct packed {
        logic               ok;
        logic signed [15:0] term_coefficient;
        logic signed [15:0] term_exponent;
        logic        [7:0]  term_variable;
        logic        [4:0]  entries;
    } t_out_word;

    // one table entry
    typedef struct packed {
        logic signed [15:0] coefficient;
        logic signed [15:0] exponent;
        logic        [7:0]  variable;
    } t_term;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_PUT,
        ST_REM_RD,
        ST_REM_CHK,
        ST_SHF_RD,
        ST_SHF_WR,
        ST_RD_WAIT,
        ST_FIN
    } t_state;

    // read address select
    typedef enum logic [1:0] {
        RD_IDX_M1,
        RD_IDX,
        RD_IDX_P1,
        RD_POS
    } t_rd_sel;

    typedef struct packed {
        logic    load_item;
        logic    idx_zero_ld;
        logic    idx_inc;
        logic    idx_dec;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_shift;
        logic    wr_item;
        logic    count_inc;
        logic    count_dec;
        logic    count_clr;
        logic    ok_set;
        logic    term_set;
        logic    res_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic idx_zero;
        logic idx_at_count;
        logic idx_last;
        logic rd_ge;
        logic rd_eq;
        logic pos_ok;
        logic out_free;
    } t_status;

endpackage

// File: rtl/core/stl_ctrl.sv
module stl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  stl_pkg::t_status i_status,
    output stl_pkg::t_cmd   o_cmd
);
    import stl_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (i_status.op)
                    OP_INSERT: begin
                        n_state = i_status.full ? ST_FIN : ST_INS_RD;
                    end
                    OP_REMOVE: begin
                        o_cmd.idx_zero_ld = 1'b1;
                        n_state           = ST_REM_RD;
                    end
                    OP_READ: begin
                        if (i_status.pos_ok) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_POS;
                            n_state      = ST_RD_WAIT;
                        end else begin
                            n_state = ST_FIN;
                        end
                    end
                    default: begin
                        o_cmd.count_clr = 1'b1;
                        o_cmd.ok_set    = 1'b1;
                        n_state         = ST_FIN;
                    end
                endcase
            end
            // walk down from the top, moving larger-or-equal keys up one slot
            ST_INS_RD: begin
                if (i_status.idx_zero) begin
                    n_state = ST_INS_PUT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_M1;
                    n_state      = ST_INS_CHK;
                end
            end
            ST_INS_CHK: begin
                if (i_status.rd_ge) begin
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.idx_dec  = 1'b1;
                    n_state        = ST_INS_RD;
                end else begin
                    n_state = ST_INS_PUT;
                end
            end
            ST_INS_PUT: begin
                o_cmd.wr_item   = 1'b1;
                o_cmd.count_inc = 1'b1;
                o_cmd.ok_set    = 1'b1;
                n_state         = ST_FIN;
            end
            // search up from the bottom for the first key not below the target
            ST_REM_RD: begin
                if (i_status.idx_at_count) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = ST_REM_CHK;
                end
            end
            ST_REM_CHK: begin
                if (!i_status.rd_ge) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ST_REM_RD;
                end else if (i_status.rd_eq) begin
                    n_state = ST_SHF_RD;
                end else begin
                    n_state = ST_FIN;
                end
            end
            // close the gap: entry idx+1 moves to idx
            ST_SHF_RD: begin
                if (i_status.idx_last) begin
                    o_cmd.count_dec = 1'b1;
                    o_cmd.ok_set    = 1'b1;
                    n_state         = ST_FIN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_P1;
                    n_state      = ST_SHF_WR;
                end
            end
            ST_SHF_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = ST_SHF_RD;
            end
            ST_RD_WAIT: begin
                o_cmd.ok_set   = 1'b1;
                o_cmd.term_set = 1'b1;
                n_state        = ST_FIN;
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/stl_dp.sv
module stl_dp #(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stl_pkg::t_in_word i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output stl_pkg::t_out_word o_word,
    input  stl_pkg::t_cmd     i_cmd,
    output stl_pkg::t_status  o_status
);
    import stl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int CW = (IW > 8) ? IW : 8;

    t_term     r_mem [CAPACITY];
    t_term     r_rd;
    t_in_word  r_item;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_count;
    logic          r_ok;
    logic          r_term_sel;
    logic          r_out_valid;
    t_out_word     r_out;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    t_term         wr_data;
    t_term         item_term;
    t_out_word     n_out;

    assign item_term = '{coefficient: r_item.coefficient,
                         exponent:    r_item.exponent,
                         variable:    r_item.variable};

    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX_M1: rd_addr = AW'(r_idx - IW'(1));
            RD_IDX:    rd_addr = AW'(r_idx);
            RD_IDX_P1: rd_addr = AW'(r_idx + IW'(1));
            RD_POS:    rd_addr = AW'(r_item.position - 8'd1);
            default:   rd_addr = '0;
        endcase
    end

    assign wr_en   = i_cmd.wr_shift | i_cmd.wr_item;
    assign wr_addr = AW'(r_idx);
    assign wr_data = i_cmd.wr_item ? item_term : r_rd;

    // table memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.count_clr) begin
            r_count <= '0;
        end else if (i_cmd.count_inc) begin
            r_count <= r_count + IW'(1);
        end else if (i_cmd.count_dec) begin
            r_count <= r_count - IW'(1);
        end
    end

    // insert starts at the fill count, remove at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load_item) begin
            r_idx <= r_count;
        end else if (i_cmd.idx_zero_ld) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IW'(1);
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok       <= 1'b0;
            r_term_sel <= 1'b0;
        end else if (i_cmd.load_item) begin
            r_ok       <= 1'b0;
            r_term_sel <= 1'b0;
        end else begin
            if (i_cmd.ok_set) begin
                r_ok <= 1'b1;
            end
            if (i_cmd.term_set) begin
                r_term_sel <= 1'b1;
            end
        end
    end

    always_comb begin
        n_out.ok               = r_ok;
        n_out.term_coefficient = r_term_sel ? r_rd.coefficient : 16'sd0;
        n_out.term_exponent    = r_term_sel ? r_rd.exponent : 16'sd0;
        n_out.term_variable    = r_term_sel ? r_rd.variable : 8'd0;
        n_out.entries          = 5'(r_count);
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_comb begin
        o_status.op           = r_item.op;
        o_status.full         = (r_count == IW'(CAPACITY));
        o_status.idx_zero     = (r_idx == '0);
        o_status.idx_at_count = (r_idx == r_count);
        o_status.idx_last     = ((r_idx + IW'(1)) == r_count);
        o_status.rd_ge        = ($signed(r_rd.coefficient) >= $signed(r_item.coefficient));
        o_status.rd_eq        = (r_rd.coefficient == r_item.coefficient);
        o_status.pos_ok       = (r_item.position != 8'd0) &&
                                (CW'(r_item.position) <= CW'(r_count));
        o_status.out_free     = !r_out_valid || i_ready;
    end

endmodule

// File: rtl/core/sorted_term_list.sv
// Sorted term list: a table of up to CAPACITY terms (coefficient, exponent,
// variable) kept in ascending order of signed coefficient, driven by one
// operation word at a time (insert, remove by coefficient, read at a 1-based
// position, clear) and answering each with one result word. Words are taken
// one at a time; the next one is accepted as soon as the previous one has been
// placed in the output register, even if that result is still waiting. The
// table lives in a memory with one write and one registered read per cycle. An
// insert moves each larger-or-equal entry up one slot from the top down and then
// writes the new term; a remove scans up from the bottom for the first key not
// below the target and, on a match, moves each entry above it down one slot.
// An insert into a full table, a failed read and a clear skip the table walk.
// entries reports the fill count after the operation, low five bits.
module sorted_term_list #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  stl_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output stl_pkg::t_out_word o_word
);
    import stl_pkg::*;

    t_cmd    cmd;
    t_status status;

    stl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    stl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (i_word),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_word   (o_word),
        .i_cmd    (cmd),
        .o_status (status)
    );

`include "sorted_term_list_defines.svh"

    // a failed operation never reports a term
    `STL_ASSERT_NOW(a_fail_no_term, o_valid && !o_word.ok, o_word.term_coefficient == 16'sd0 && o_word.term_exponent == 16'sd0 && o_word.term_variable == 8'd0, "failed word carries a term")

    // one word in flight: accepting closes the input until the work is done
    `STL_ASSERT_NEXT(a_one_in_flight, i_valid && o_ready, !o_ready, "input accepted twice in a row")

    // a new result is only loaded into a free output register
    `STL_ASSERT_NOW(a_no_overwrite, cmd.res_load, !o_valid || i_ready, "result overwrites a waiting word")

endmodule

// File: tb/testbench.sv
module testbench;
    import stl_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RAND_ITEMS   = 500;
    localparam int PHASE_LEN    = RAND_ITEMS / 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 500000;

    // idling phases
    localparam int unsigned PH_FREE     = 0;
    localparam int unsigned PH_TX_IDLE  = 1;
    localparam int unsigned PH_RX_STALL = 2;
    localparam int unsigned PH_BOTH     = 3;

    typedef struct {
        t_in_word    word;
        int unsigned phase;
        bit          wait_drain;
        bit          hold_rx;
    } t_op_item;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_word  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_word;

    sorted_term_list #(.CAPACITY(CAPACITY)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

    t_op_item    pending_ops[$];
    t_out_word   expected_results[$];
    logic [15:0] gen_keys[$];

    // predicted table contents
    t_term       term_tbl [CAPACITY];
    int          term_cnt       = 0;

    int          n_sent         = 0;
    int          n_checked      = 0;
    int          n_full_refused = 0;
    int          n_missed       = 0;
    int          n_errors       = 0;
    int          cycle_cnt      = 0;
    int unsigned rx_phase       = PH_FREE;
    int unsigned hold_left      = 0;
    logic        hold_go        = 1'b0;
    bit          offer_free;
    bit          hold_go_nx;
    t_out_word   want;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_pct(int unsigned ph, bit rx_side);
        case (ph)
            PH_TX_IDLE:  return rx_side ? 0 : 68;
            PH_RX_STALL: return rx_side ? 68 : 0;
            PH_BOTH:     return 10;
            default:     return 0;
        endcase
    endfunction

    // index of first entry with coefficient >= key
    function automatic int first_not_less(logic signed [15:0] key);
        int at;
        at = 0;
        while (at < term_cnt && $signed(term_tbl[at].coefficient) < key)
            at++;
        return at;
    endfunction

    function automatic t_out_word apply_op(t_in_word w);
        t_out_word r;
        int at;
        int i;
        r = '0;
        case (w.op)
            OP_INSERT: begin
                if (term_cnt < CAPACITY) begin
                    at = first_not_less(w.coefficient);
                    for (i = term_cnt; i > at; i--)
                        term_tbl[i] = term_tbl[i - 1];
                    term_tbl[at].coefficient = w.coefficient;
                    term_tbl[at].exponent    = w.exponent;
                    term_tbl[at].variable    = w.variable;
                    term_cnt++;
                    r.ok = 1'b1;
                end else begin
                    n_full_refused++;
                end
            end
            OP_REMOVE: begin
                at = first_not_less(w.coefficient);
                if (at < term_cnt && term_tbl[at].coefficient == w.coefficient) begin
                    for (i = at; i + 1 < term_cnt; i++)
                        term_tbl[i] = term_tbl[i + 1];
                    term_cnt--;
                    r.ok = 1'b1;
                end else begin
                    n_missed++;
                end
            end
            OP_READ: begin
                if (w.position >= 1 && int'(w.position) <= term_cnt) begin
                    r.ok               = 1'b1;
                    r.term_coefficient = term_tbl[w.position - 1].coefficient;
                    r.term_exponent    = term_tbl[w.position - 1].exponent;
                    r.term_variable    = term_tbl[w.position - 1].variable;
                end else begin
                    n_missed++;
                end
            end
            default: begin
                term_cnt = 0;
                r.ok     = 1'b1;
            end
        endcase
        r.entries = 5'(term_cnt);
        return r;
    endfunction

    function automatic t_in_word mk_word(t_op op, logic [15:0] coef, logic [15:0] expo,
                                         logic [7:0] var_code, logic [7:0] pos);
        t_in_word w;
        w.op          = op;
        w.coefficient = coef;
        w.exponent    = expo;
        w.variable    = var_code;
        w.position    = pos;
        return w;
    endfunction

    // mostly a small pool so duplicates and hits are common
    function automatic logic [15:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 16'(int'($urandom_range(0, 8)) - 4);
        else if (r == 5)
            return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        else
            return 16'($urandom());
    endfunction

    function automatic t_in_word rand_word();
        t_in_word    w;
        int unsigned r;
        int          n;
        n = gen_keys.size();
        w = mk_word(OP_READ, pick_key(), 16'($urandom()), 8'($urandom()), 8'($urandom()));
        r = $urandom_range(0, 99);
        if (r < 4) begin
            w.op = OP_CLEAR;
        end else if (r < 50) begin
            w.op = OP_INSERT;
        end else if (r < 72) begin
            w.op = OP_REMOVE;
            if (n > 0 && $urandom_range(0, 3) != 0)
                w.coefficient = gen_keys[$urandom_range(0, n - 1)];
        end else begin
            r = $urandom_range(0, 99);
            if (r < 80 && n > 0)
                w.position = 8'($urandom_range(1, n));
            else if (r < 87)
                w.position = 8'd0;
            else if (r < 94)
                w.position = 8'(n + 1);
        end
        return w;
    endfunction

    task automatic add_item(t_in_word w, int unsigned ph, bit drain, bit hold);
        t_op_item s;
        int       k;
        s.word       = w;
        s.phase      = ph;
        s.wait_drain = drain;
        s.hold_rx    = hold;
        pending_ops.push_back(s);
        case (w.op)
            OP_INSERT: if (gen_keys.size() < CAPACITY) gen_keys.push_back(w.coefficient);
            OP_REMOVE: begin
                for (k = 0; k < gen_keys.size(); k++)
                    if (gen_keys[k] == w.coefficient) break;
                if (k < gen_keys.size()) gen_keys.delete(k);
            end
            OP_CLEAR:  gen_keys.delete();
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // stimulus and end of run
    initial begin : stim
        int          i;
        int unsigned ph;
        add_item(mk_word(OP_READ,   16'd0,    16'd0,    8'd0,   8'd0),   PH_FREE, 0, 0);
        add_item(mk_word(OP_REMOVE, 16'd7,    16'd0,    8'd0,   8'd0),   PH_FREE, 0, 0);
        add_item(mk_word(OP_CLEAR,  16'd0,    16'd0,    8'd0,   8'd0),   PH_FREE, 0, 0);
        add_item(mk_word(OP_INSERT, 16'd0,    16'h1111, "x",    8'd0),   PH_FREE, 0, 0);
        add_item(mk_word(OP_INSERT, 16'h8000, 16'h7fff, 8'hff,  8'hff),  PH_FREE, 0, 0);
        add_item(mk_word(OP_INSERT, 16'h7fff, 16'h8000, 8'h00,  8'd0),   PH_FREE, 0, 0);
        // equal key lands ahead of the older one
        add_item(mk_word(OP_INSERT, 16'd0,    16'h2222, "y",    8'd0),   PH_FREE, 0, 0);
        add_item(mk_word(OP_READ,   16'd0,    16'd0,    8'd0,   8'd2),   PH_FREE, 0, 0);
        add_item(mk_word(OP_READ,   16'd0,    16'd0,    8'd0,   8'd3),   PH_FREE, 0, 0);
        add_item(mk_word(OP_READ,   16'd0,    16'd0,    8'd0,   8'd4),   PH_FREE, 0, 0);
        add_item(mk_word(OP_READ,   16'd0,    16'd0,    8'd0,   8'd255), PH_FREE, 0, 0);
        add_item(mk_word(OP_REMOVE, 16'd0,    16'd0,    8'd0,   8'd0),   PH_FREE, 0, 0);
        add_item(mk_word(OP_REMOVE, 16'd5,    16'd0,    8'd0,   8'd0),   PH_FREE, 0, 0);
        add_item(mk_word(OP_READ,   16'd0,    16'd0,    8'd0,   8'd2),   PH_FREE, 0, 0);
        while (gen_keys.size() < CAPACITY)
            add_item(mk_word(OP_INSERT, pick_key(), 16'($urandom()), 8'($urandom()), 8'd0),
                     PH_FREE, 0, 0);
        add_item(mk_word(OP_INSERT, 16'd1,    16'd1,    "z",    8'd0),   PH_FREE, 0, 0);
        add_item(mk_word(OP_READ,   16'd0,    16'd0,    8'd0,   8'd16),  PH_FREE, 0, 0);
        add_item(mk_word(OP_CLEAR,  16'hffff, 16'hffff, 8'hff,  8'hff),  PH_FREE, 0, 0);

        for (i = 0; i < RAND_ITEMS; i++) begin
            ph = int'(i / PHASE_LEN);
            if (ph > PH_BOTH) ph = PH_BOTH;
            add_item(rand_word(), ph, (i % PHASE_LEN) == 0, i == 40);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words, checked %0d results in %0d cycles", n_sent, n_checked,
                 cycle_cnt);
        $display("Full-table inserts refused: %0d, failed removes/reads: %0d",
                 n_full_refused, n_missed);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d words still pending", cycle_cnt,
                 pending_ops.size());
        $display("CHECK FAILED");
        $finish;
    end

    // driver: predicts each word as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            hold_go <= 1'b0;
        end else begin
            hold_go_nx = 1'b0;
            offer_free = !i_valid;
            if (i_valid && o_ready) begin
                expected_results.push_back(apply_op(pending_ops[0].word));
                hold_go_nx = pending_ops[0].hold_rx;
                rx_phase  <= pending_ops[0].phase;
                pending_ops.pop_front();
                n_sent++;
                offer_free = 1'b1;
            end
            hold_go <= hold_go_nx;
            if (offer_free) begin
                if (pending_ops.size() != 0 &&
                    !(pending_ops[0].wait_drain && expected_results.size() != 0) &&
                    $urandom_range(0, 99) >= idle_pct(pending_ops[0].phase, 1'b0)) begin
                    i_valid <= 1'b1;
                    i_word  <= pending_ops[0].word;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result word with nothing expected, actual %h", $time, o_word);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok",               16'(want.ok),   16'(o_word.ok));
                    check_field("term_coefficient", want.term_coefficient,
                                o_word.term_coefficient);
                    check_field("term_exponent",    want.term_exponent, o_word.term_exponent);
                    check_field("term_variable",    16'(want.term_variable),
                                16'(o_word.term_variable));
                    check_field("entries",          16'(want.entries), 16'(o_word.entries));
                    n_checked++;
                end
            end
            i_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(rx_phase, 1'b1));
        end
    end

endmodule
